/* rtl/core/bfa_pkg.sv */
// ----------------------------------------------------------------------------
// Bitmap frame allocator package
// Shared widths, reset values, request and status codes, and register indexes.
// ----------------------------------------------------------------------------
package bfa_pkg;

    localparam int ADDR_W      = 32;
    localparam int COUNT_W     = 13;
    localparam int STATUS_W    = 2;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam int FRAME_BYTES   = 4096;
    localparam int FRAME_SHIFT   = $clog2(FRAME_BYTES);
    localparam int FRAME_NUM_W   = ADDR_W - FRAME_SHIFT;
    localparam int MAP_WORD_BITS = 32;

    localparam logic [ADDR_W-1:0]  RESET_BASE_ADDRESS  = 32'h0020_0000;
    localparam int                 RESET_WINDOW_FRAMES = 3584;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_NONE    = 2'd1;
    localparam status_t ST_BADADDR = 2'd2;
    localparam status_t ST_DOUBLE  = 2'd3;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic CFG_BASE_ADDRESS  = 1'b0;
    localparam logic CFG_WINDOW_FRAMES = 1'b1;

endpackage

/* rtl/core/bfa_req_if.sv */
// ----------------------------------------------------------------------------
// Allocator request channel
// Carries one allocate or free request item with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bfa_req_if
    import bfa_pkg::*;
();

    logic              valid;
    logic              ready;
    logic              req_type;
    logic [ADDR_W-1:0] frame_address;

    modport source (
        output valid,
        output req_type,
        output frame_address,
        input  ready
    );

    modport sink (
        input  valid,
        input  req_type,
        input  frame_address,
        output ready
    );

endinterface

/* rtl/core/bfa_rsp_if.sv */
// ----------------------------------------------------------------------------
// Allocator response channel
// Carries one result item with status, granted address and free frame count.
// ----------------------------------------------------------------------------
interface bfa_rsp_if
    import bfa_pkg::*;
();

    logic               valid;
    logic               ready;
    status_t            status;
    logic [ADDR_W-1:0]  granted_address;
    logic [COUNT_W-1:0] free_count;

    modport source (
        output valid,
        output status,
        output granted_address,
        output free_count,
        input  ready
    );

    modport sink (
        input  valid,
        input  status,
        input  granted_address,
        input  free_count,
        output ready
    );

endinterface

/* rtl/core/bfa_map_ram.sv */
// ----------------------------------------------------------------------------
// Bitmap word memory
// Synchronous memory of bitmap words with one read and one write port, a
// registered read word, and a valid bit per row so that a clear takes effect at
// once. A row that has not been written since the last clear reads as zero.
// ----------------------------------------------------------------------------
module bfa_map_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 32,
    parameter int IDX_W = 7
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             clear,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output logic [WIDTH-1:0] rd_word,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] row_vld_reg;
    logic [WIDTH-1:0] rd_data_reg;
    logic             rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            if (clear)
            begin
                row_vld_reg <= '0;
            end
            else if (wr_en)
            begin
                row_vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= row_vld_reg[rd_addr];
            end
        end
    end

    assign rd_word = rd_vld_reg ? rd_data_reg : '0;

endmodule

/* rtl/core/bitmap_frame_allocator.sv */
// ----------------------------------------------------------------------------
// Bitmap frame allocator
// Keeps one used bit per page frame in a word-wide bitmap memory. An allocate
// item takes the lowest free frame and returns its byte address; a free item
// checks range, alignment and used state before releasing the frame.
//
//   Channel  Role    Handshake         Contents
//   req      sink    valid/ready       req_type, frame_address
//   rsp      source  valid/ready       status, granted_address, free_count
//   APB      slave   psel/penable      window base (0x0), window size (0x4)
//
// A free item is checked in S_FCHK, against its bitmap word if in range. An
// allocate item reads word 0 when accepted, then further words one at a time
// through the single read port in S_SCAN until a word with a clear bit or the
// last word, and sets the bit in S_ADEC. A configuration write clears the
// whole bitmap at once and holds off new items while the free count reloads.
// A result waits in the output register while the next item is accepted; a
// stalled result holds the finishing item until the output register frees.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator
    import bfa_pkg::*;
#(
    parameter int MAX_FRAMES    = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    bfa_req_if.sink            req,
    bfa_rsp_if.source          rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int MAP_WORDS  = (MAX_FRAMES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int WORD_IDX_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_IDX_W  = $clog2(MAP_WORD_BITS);
    localparam int LIM_W      = FRAME_NUM_W + 1;

    localparam logic [COUNT_W-1:0] RESET_USABLE =
        COUNT_W'((RESET_WINDOW_FRAMES > MAX_FRAMES) ? MAX_FRAMES : RESET_WINDOW_FRAMES);
    localparam logic [LIM_W-1:0]      MAX_LIM   = LIM_W'(MAX_FRAMES);
    localparam logic [WORD_IDX_W-1:0] LAST_WORD = WORD_IDX_W'(MAP_WORDS - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_ADEC = 2'd2;
    localparam logic [1:0] S_FCHK = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic                   restart_reg;
    logic [ADDR_W-1:0]      base_reg;
    logic [COUNT_W-1:0]     fc_reg;
    logic [COUNT_W-1:0]     usable_reg;
    logic [COUNT_W-1:0]     free_total_reg, free_total_next;
    logic [WORD_IDX_W-1:0]  chk_idx_reg, chk_idx_next;
    logic [FRAME_NUM_W-1:0] frame_idx_reg, frame_idx_next;
    logic                   bad_reg, bad_next;

    logic                   out_vld_reg, out_vld_next;
    status_t                out_status_reg, out_status_next;
    logic [ADDR_W-1:0]      out_granted_reg, out_granted_next;
    logic [COUNT_W-1:0]     out_free_reg, out_free_next;

    logic                   cfg_wr;
    logic [LIM_W-1:0]       fit_lim;
    logic [LIM_W-1:0]       usable_lim;

    logic                   accept;
    logic                   slot_free;
    logic                   out_load;
    logic [ADDR_W-1:0]      req_off;
    logic [FRAME_NUM_W-1:0] req_frame;
    logic                   req_bad;

    logic                     rd_en;
    logic [WORD_IDX_W-1:0]    rd_addr;
    logic [MAP_WORD_BITS-1:0] rd_word;
    logic                     wr_en;
    logic [WORD_IDX_W-1:0]    wr_addr;
    logic [MAP_WORD_BITS-1:0] wr_data;

    logic                     word_full;
    logic                     scan_stop;
    logic [BIT_IDX_W-1:0]     zb_idx;
    logic [FRAME_NUM_W-1:0]   alloc_frame;
    logic                     alloc_ok;
    logic [BIT_IDX_W-1:0]     free_bit;
    logic [WORD_IDX_W-1:0]    free_word;
    logic [MAP_WORD_BITS-1:0] free_mask;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == CFG_WINDOW_FRAMES) ? PDATA_W'(fc_reg) : base_reg;

    // Frames that fit: the window size, capped by the built capacity and by
    // the address space left above base_address.
    always_comb
    begin
        fit_lim    = {1'b0, ~base_reg[ADDR_W-1:FRAME_SHIFT]} + LIM_W'(1);
        usable_lim = LIM_W'(fc_reg);
        if (MAX_LIM < usable_lim)
        begin
            usable_lim = MAX_LIM;
        end
        if (fit_lim < usable_lim)
        begin
            usable_lim = fit_lim;
        end
    end

    // Request decode for a free item.
    assign req_off   = req.frame_address - base_reg;
    assign req_frame = req_off[ADDR_W-1:FRAME_SHIFT];
    assign req_bad   = (req.frame_address < base_reg)
                    || (req_off[FRAME_SHIFT-1:0] != '0)
                    || (req_frame >= FRAME_NUM_W'(usable_reg));

    assign req.ready = (state_reg == S_IDLE) && !restart_reg;
    assign accept    = req.valid && req.ready;
    assign slot_free = !out_vld_reg || rsp.ready;

    // Scan of the word that has just been read.
    always_comb
    begin
        zb_idx = '0;
        for (int i = MAP_WORD_BITS - 1; i >= 0; i--)
        begin
            if (!rd_word[i])
            begin
                zb_idx = BIT_IDX_W'(i);
            end
        end
    end

    assign word_full   = &rd_word;
    assign scan_stop   = !word_full || (chk_idx_reg == LAST_WORD);
    assign alloc_frame = FRAME_NUM_W'({chk_idx_reg, zb_idx});
    assign alloc_ok    = !word_full && (alloc_frame < FRAME_NUM_W'(usable_reg));

    assign free_bit  = frame_idx_reg[BIT_IDX_W-1:0];
    assign free_word = frame_idx_reg[BIT_IDX_W +: WORD_IDX_W];
    assign free_mask = MAP_WORD_BITS'(1) << free_bit;

    always_comb
    begin
        state_next       = state_reg;
        chk_idx_next     = chk_idx_reg;
        frame_idx_next   = frame_idx_reg;
        bad_next         = bad_reg;
        free_total_next  = free_total_reg;
        out_load         = 1'b0;
        out_status_next  = out_status_reg;
        out_granted_next = out_granted_reg;
        out_free_next    = out_free_reg;
        rd_en            = 1'b0;
        rd_addr          = chk_idx_reg + WORD_IDX_W'(1);
        wr_en            = 1'b0;
        wr_addr          = chk_idx_reg;
        wr_data          = rd_word | (MAP_WORD_BITS'(1) << zb_idx);

        unique case (state_reg)
            S_IDLE:
            begin
                if (restart_reg)
                begin
                    free_total_next = COUNT_W'(usable_lim);
                end
                else if (accept)
                begin
                    if (req.req_type == REQ_ALLOC)
                    begin
                        rd_en        = 1'b1;
                        rd_addr      = '0;
                        chk_idx_next = '0;
                        state_next   = S_SCAN;
                    end
                    else
                    begin
                        rd_en          = !req_bad;
                        rd_addr        = req_frame[BIT_IDX_W +: WORD_IDX_W];
                        frame_idx_next = req_frame;
                        bad_next       = req_bad;
                        state_next     = S_FCHK;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_stop)
                begin
                    state_next = S_ADEC;
                end
                else
                begin
                    rd_en        = 1'b1;
                    chk_idx_next = chk_idx_reg + WORD_IDX_W'(1);
                end
            end
            S_ADEC:
            begin
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                    if (alloc_ok)
                    begin
                        wr_en = 1'b1;
                        if (free_total_reg != '0)
                        begin
                            free_total_next = free_total_reg - COUNT_W'(1);
                        end
                        out_status_next  = ST_OK;
                        out_granted_next = base_reg + {alloc_frame, {FRAME_SHIFT{1'b0}}};
                    end
                    else
                    begin
                        out_status_next  = ST_NONE;
                        out_granted_next = '0;
                    end
                    out_free_next = free_total_next;
                end
            end
            S_FCHK:
            begin
                if (slot_free)
                begin
                    out_load         = 1'b1;
                    state_next       = S_IDLE;
                    out_granted_next = '0;
                    wr_addr          = free_word;
                    wr_data          = rd_word & ~free_mask;
                    priority if (bad_reg)
                    begin
                        out_status_next = ST_BADADDR;
                    end
                    else if (!rd_word[free_bit])
                    begin
                        out_status_next = ST_DOUBLE;
                    end
                    else
                    begin
                        wr_en           = 1'b1;
                        free_total_next = free_total_reg + COUNT_W'(1);
                        out_status_next = ST_OK;
                    end
                    out_free_next = free_total_next;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_vld_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            restart_reg    <= 1'b0;
            base_reg       <= RESET_BASE_ADDRESS;
            fc_reg         <= COUNT_W'(RESET_WINDOW_FRAMES);
            usable_reg     <= RESET_USABLE;
            free_total_reg <= RESET_USABLE;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            free_total_reg <= free_total_next;
            out_vld_reg    <= out_vld_next;
            restart_reg    <= cfg_wr;
            if (restart_reg)
            begin
                usable_reg <= COUNT_W'(usable_lim);
            end
            if (cfg_wr)
            begin
                if (paddr[2] == CFG_BASE_ADDRESS)
                begin
                    base_reg <= pwdata;
                end
                else
                begin
                    fc_reg <= pwdata[COUNT_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg     <= chk_idx_next;
        frame_idx_reg   <= frame_idx_next;
        bad_reg         <= bad_next;
        out_status_reg  <= out_status_next;
        out_granted_reg <= out_granted_next;
        out_free_reg    <= out_free_next;
    end

    bfa_map_ram #(
        .DEPTH (MAP_WORDS),
        .WIDTH (MAP_WORD_BITS),
        .IDX_W (WORD_IDX_W)
    ) u_map_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (cfg_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_word (rd_word),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign rsp.valid           = out_vld_reg;
    assign rsp.status          = out_status_reg;
    assign rsp.granted_address = out_granted_reg;
    assign rsp.free_count      = out_free_reg;

endmodule

/* test/frame_ledger_pkg.sv */
// ----------------------------------------------------------------------------
// Frame ledger for the bitmap frame allocator testbench
// Tracks the used bit of every frame, the free count and the window settings,
// works out the result of each accepted request and checks returned results.
// ----------------------------------------------------------------------------
package frame_ledger_pkg;

    import bfa_pkg::*;

    localparam int LEDGER_FRAMES = 4096;

    typedef struct packed {
        status_t            status;
        logic [ADDR_W-1:0]  granted_address;
        logic [COUNT_W-1:0] free_count;
    } frame_result_t;

    class frame_ledger;

        logic [ADDR_W-1:0]  base_address;
        logic [COUNT_W-1:0] window_frames;
        bit                 frame_used [LEDGER_FRAMES];
        int unsigned        free_total;
        int unsigned        held_frames [$];
        frame_result_t      pending_results [$];
        int unsigned        errors;

        function new();
            base_address  = RESET_BASE_ADDRESS;
            window_frames = COUNT_W'(RESET_WINDOW_FRAMES);
            errors        = 0;
            restart();
        endfunction

        // Frames that the window holds: the count register, capped at the
        // capacity and at the frames whose addresses all lie below 2^32.
        function int unsigned usable_frames();
            longint unsigned n;
            longint unsigned fit;
            n   = window_frames;
            fit = (64'hFFFF_FFFF - 64'(base_address)) / FRAME_BYTES + 1;
            if (n > LEDGER_FRAMES)
                n = LEDGER_FRAMES;
            if (n > fit)
                n = fit;
            return int'(n);
        endfunction

        function void restart();
            foreach (frame_used[i])
                frame_used[i] = 1'b0;
            held_frames.delete();
            free_total = usable_frames();
        endfunction

        function void configure(logic index, logic [PDATA_W-1:0] value);
            if (index == CFG_BASE_ADDRESS)
                base_address = value;
            else
                window_frames = value[COUNT_W-1:0];
            restart();
        endfunction

        function logic [ADDR_W-1:0] frame_at(int unsigned n);
            return base_address + ADDR_W'(n * FRAME_BYTES);
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction

        function void note_request(logic kind, logic [ADDR_W-1:0] address);
            frame_result_t     r;
            int unsigned       limit;
            int unsigned       n;
            logic [ADDR_W-1:0] offset;
            limit             = usable_frames();
            r.status          = ST_OK;
            r.granted_address = '0;
            if (kind == REQ_ALLOC)
            begin
                for (n = 0; n < LEDGER_FRAMES && frame_used[n]; n++)
                    ;
                if (n < limit)
                begin
                    frame_used[n] = 1'b1;
                    if (free_total > 0)
                        free_total--;
                    r.granted_address = frame_at(n);
                    held_frames.push_back(n);
                end
                else
                    r.status = ST_NONE;
            end
            else if (address < base_address)
                r.status = ST_BADADDR;
            else
            begin
                offset = address - base_address;
                n      = offset >> FRAME_SHIFT;
                if (offset[FRAME_SHIFT-1:0] != '0 || n >= limit)
                    r.status = ST_BADADDR;
                else if (!frame_used[n])
                    r.status = ST_DOUBLE;
                else
                begin
                    frame_used[n] = 1'b0;
                    free_total++;
                    for (int j = 0; j < held_frames.size(); j++)
                    begin
                        if (held_frames[j] == n)
                        begin
                            held_frames.delete(j);
                            break;
                        end
                    end
                end
            end
            r.free_count = COUNT_W'(free_total);
            pending_results.push_back(r);
        endfunction

        function void check_result(status_t status, logic [ADDR_W-1:0] granted,
                                   logic [COUNT_W-1:0] free_count);
            frame_result_t due;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: status %0d address %h free %0d",
                         $time, status, granted, free_count);
                return;
            end
            due = pending_results.pop_front();
            if (status !== due.status)
            begin
                errors++;
                $display("%0t: status expected %0d got %0d", $time, due.status, status);
            end
            if (granted !== due.granted_address)
            begin
                errors++;
                $display("%0t: granted_address expected %h got %h",
                         $time, due.granted_address, granted);
            end
            if (free_count !== due.free_count)
            begin
                errors++;
                $display("%0t: free_count expected %0d got %0d",
                         $time, due.free_count, free_count);
            end
        endfunction

    endclass

endpackage

/* test/tb_bitmap_frame_allocator.sv */
// ----------------------------------------------------------------------------
// Bitmap frame allocator testbench
// Drives allocate and free items through the request channel with random gaps
// and response stalls, reprograms the frame window over the register port
// between phases, and checks every result against the frame ledger.
// ----------------------------------------------------------------------------
module tb_bitmap_frame_allocator;

    import bfa_pkg::*;
    import frame_ledger_pkg::*;

    localparam logic [PADDR_W-1:0] BASE_ADDRESS_REG  = {CFG_BASE_ADDRESS, 2'b00};
    localparam logic [PADDR_W-1:0] WINDOW_FRAMES_REG = {CFG_WINDOW_FRAMES, 2'b00};
    localparam int                 RANDOM_ITEMS      = 700;
    localparam int                 QUIET_LIMIT       = 4000;
    localparam int                 DRAIN_CYCLES      = 140;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    bfa_req_if req ();
    bfa_rsp_if rsp ();

    frame_ledger ledger;
    bit          no_idle;
    int          quiet_cycles = 0;

    bitmap_frame_allocator dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp.ready <= no_idle || ($urandom_range(99) >= 10);
        end
    end

    always @(posedge clk)
    begin
        if (rsp.valid && rsp.ready)
            ledger.check_result(rsp.status, rsp.granted_address, rsp.free_count);
    end

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (psel && penable))
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("tb_bitmap_frame_allocator NOT OK");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic bit take_gap();
        return !no_idle && ($urandom_range(99) < 10);
    endfunction

    task automatic send_request(input logic kind, input logic [ADDR_W-1:0] address);
        if (take_gap())
        begin
            req.valid <= 1'b0;
            do
                @(posedge clk);
            while (take_gap());
        end
        req.valid         <= 1'b1;
        req.req_type      <= kind;
        req.frame_address <= address;
        do
            @(posedge clk);
        while (!req.ready);
        ledger.note_request(kind, address);
    endtask

    task automatic end_phase();
        req.valid <= 1'b0;
        while (ledger.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [PADDR_W-1:0] address,
                                  input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= address;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        ledger.configure(address == WINDOW_FRAMES_REG ? CFG_WINDOW_FRAMES : CFG_BASE_ADDRESS,
                         value);
        @(posedge clk);
    endtask

    task automatic set_window(input logic [ADDR_W-1:0] base, input int unsigned count);
        write_register(BASE_ADDRESS_REG, base);
        write_register(WINDOW_FRAMES_REG, PDATA_W'(count));
    endtask

    task automatic random_window();
        logic [ADDR_W-1:0] base;
        int unsigned       count;
        case ($urandom_range(3))
            0:       base = '0;
            1:       base = $urandom() & ~(ADDR_W'(FRAME_BYTES) - 1);
            2:       base = $urandom();
            default: base = 32'hFFFF_F000 - ADDR_W'($urandom_range(79) * FRAME_BYTES);
        endcase
        case ($urandom_range(9))
            6:       count = 4096;
            7:       count = $urandom_range(8191, 4097);
            8:       count = 0;
            9:       count = $urandom_range(4096, 1);
            default: count = $urandom_range(48, 1);
        endcase
        set_window(base, count);
    endtask

    // Mostly allocations and frees of frames that are held, with a share of
    // double frees, misaligned, out-of-window and arbitrary addresses.
    task automatic random_request(input int unsigned alloc_pct);
        int unsigned       pick;
        int unsigned       limit;
        logic [ADDR_W-1:0] address;
        pick  = $urandom_range(99);
        limit = ledger.usable_frames();
        if (pick < alloc_pct || (pick < 90 && ledger.held_frames.size() == 0))
            send_request(REQ_ALLOC, $urandom());
        else if (pick < 90)
        begin
            address = ledger.frame_at(
                ledger.held_frames[$urandom_range(ledger.held_frames.size() - 1)]);
            send_request(REQ_FREE, address);
        end
        else
        begin
            case ($urandom_range(3))
                0:       address = ledger.frame_at($urandom_range(limit + 2));
                1:       address = ledger.frame_at($urandom_range(limit))
                                   + ADDR_W'($urandom_range(FRAME_BYTES - 1, 1));
                2:       address = $urandom();
                default: address = ledger.base_address
                                   - ADDR_W'($urandom_range(3, 1) * FRAME_BYTES);
            endcase
            send_request(REQ_FREE, address);
        end
    endtask

    initial
    begin
        int unsigned       sent;
        int unsigned       phase;
        int unsigned       phase_items;
        int unsigned       alloc_pct;
        logic [ADDR_W-1:0] b;

        ledger            = new();
        no_idle           = 1'b0;
        rst_n             <= 1'b0;
        req.valid         <= 1'b0;
        req.req_type      <= REQ_ALLOC;
        req.frame_address <= '0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        b = RESET_BASE_ADDRESS;
        send_request(REQ_ALLOC, '0);
        send_request(REQ_ALLOC, '0);
        send_request(REQ_ALLOC, '0);
        send_request(REQ_FREE, b + FRAME_BYTES);
        send_request(REQ_FREE, b + FRAME_BYTES);
        send_request(REQ_ALLOC, 32'hFFFF_FFFF);
        send_request(REQ_FREE, '0);
        send_request(REQ_FREE, 32'hFFFF_FFFF);
        send_request(REQ_FREE, b + 1);
        send_request(REQ_FREE, b + 2 * FRAME_BYTES + FRAME_BYTES / 2);
        send_request(REQ_FREE, b + 3584 * FRAME_BYTES);
        send_request(REQ_FREE, b + 3583 * FRAME_BYTES);
        send_request(REQ_FREE, b - FRAME_BYTES);
        send_request(REQ_FREE, b);
        end_phase();

        set_window('0, 1);
        send_request(REQ_ALLOC, '0);
        send_request(REQ_ALLOC, '0);
        send_request(REQ_FREE, '0);
        send_request(REQ_FREE, '0);
        send_request(REQ_FREE, FRAME_BYTES);
        end_phase();

        set_window('0, 0);
        send_request(REQ_ALLOC, '0);
        send_request(REQ_FREE, '0);
        end_phase();

        set_window(32'hFFFF_FFFF, 4096);
        send_request(REQ_ALLOC, '0);
        send_request(REQ_ALLOC, '0);
        send_request(REQ_FREE, 32'hFFFF_FFFF);
        end_phase();

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            no_idle     = (phase == 2);
            random_window();
            alloc_pct   = $urandom_range(75, 35);
            phase_items = $urandom_range(75, 45);
            repeat (phase_items) random_request(alloc_pct);
            sent += phase_items;
            end_phase();
            phase++;
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (ledger.errors == 0 && ledger.pending() == 0)
            $display("tb_bitmap_frame_allocator OK");
        else
            $display("tb_bitmap_frame_allocator NOT OK");
        $finish;
    end

endmodule

/* bitmap_frame_allocator.f */
rtl/core/bfa_pkg.sv
rtl/core/bfa_req_if.sv
rtl/core/bfa_rsp_if.sv
rtl/core/bfa_map_ram.sv
rtl/core/bitmap_frame_allocator.sv
test/frame_ledger_pkg.sv
test/tb_bitmap_frame_allocator.sv
